// ----- hdl/sclvt_pkg.sv -----
// ============================================================================
// sclvt_pkg
// Shared types and constants for the sorted CAN identifier last-value table.
// ============================================================================
package sclvt_pkg;

    localparam int ENTRIES     = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int KEY_W       = 30;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 64;
    localparam int RIDX_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_REPLACED = 3'd0;
    localparam logic [2:0] ACT_INSERTED = 3'd1;
    localparam logic [2:0] ACT_APPENDED = 3'd2;
    localparam logic [2:0] ACT_DROPPED  = 3'd3;
    localparam logic [2:0] ACT_READ_OK  = 3'd4;
    localparam logic [2:0] ACT_READ_BAD = 3'd5;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic              is_read;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] payload;
        logic [RIDX_W-1:0] read_index;
    } item_t;

    // One table entry.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] payload;
    } entry_t;

endpackage

// ----- hdl/sorted_can_id_last_value_table_top.sv -----
// ============================================================================
// sorted_can_id_last_value_table_top
// Last-value table for CAN frames, kept sorted by identifier key.
// ============================================================================
// The block holds up to 32 CAN frames, one per identifier, in ascending key
// order (standard frames first, then extended frames). An insert request
// replaces a matching entry, or goes in at its sorted place with later entries
// moved back; a full table loses its last entry, and a frame that sorts after
// every entry of a full table is dropped. A read request returns the entry at
// a position below the fill level. Requests are taken into an input register
// and a two-deep queue, so up to three requests can be accepted while the
// table sequencer is busy. The sequencer handles one request at a time. The
// time from acceptance to result is set by the scan and the shift through
// the table memory, one entry per cycle. The result is held in an output
// register until it is taken.
module sorted_can_id_last_value_table_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        is_extended,
    input  logic [10:0] base_id,
    input  logic [17:0] ext_id,
    input  logic [3:0]  data_length,
    input  logic [63:0] payload,
    input  logic [4:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [4:0]  position,
    output logic [5:0]  fill_level,
    output logic        out_is_extended,
    output logic [10:0] out_base_id,
    output logic [17:0] out_ext_id,
    output logic [3:0]  out_length,
    output logic [63:0] out_payload
);

    logic             push_valid;
    logic             push_ready;
    sclvt_pkg::item_t push_item;
    logic             pop_valid;
    logic             pop_ready;
    sclvt_pkg::item_t pop_item;

    sclvt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .is_extended (is_extended),
        .base_id     (base_id),
        .ext_id      (ext_id),
        .data_length (data_length),
        .payload     (payload),
        .read_index  (read_index),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    sclvt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sclvt_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .position        (position),
        .fill_level      (fill_level),
        .out_is_extended (out_is_extended),
        .out_base_id     (out_base_id),
        .out_ext_id      (out_ext_id),
        .out_length      (out_length),
        .out_payload     (out_payload)
    );

endmodule

// ----- hdl/sclvt_front.sv -----
// ============================================================================
// sclvt_front
// Input stage: accepts requests, builds the sort key and registers the
// classified request until the queue takes it.
// ============================================================================
module sclvt_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic                        is_extended,
    input  logic [10:0]                 base_id,
    input  logic [17:0]                 ext_id,
    input  logic [3:0]                  data_length,
    input  logic [63:0]                 payload,
    input  logic [4:0]                  read_index,
    output logic                        push_valid,
    input  logic                        push_ready,
    output sclvt_pkg::item_t            push_item
);

    logic             hold_valid_reg;
    sclvt_pkg::item_t hold_item_reg;
    sclvt_pkg::item_t item_next;

    // A standard frame keeps zero in the extension part of its key.
    always_comb
    begin
        item_next.is_read    = mode;
        item_next.key        = {is_extended, base_id, is_extended ? ext_id : 18'd0};
        item_next.length     = data_length;
        item_next.payload    = payload;
        item_next.read_index = read_index;
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/sclvt_queue.sv -----
// ============================================================================
// sclvt_queue
// Short first-in first-out queue of classified requests between the front
// end and the table sequencer.
// ============================================================================
module sclvt_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  sclvt_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output sclvt_pkg::item_t pop_item
);

    sclvt_pkg::item_t                   slot_reg [sclvt_pkg::QUEUE_DEPTH];
    logic [sclvt_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sclvt_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sclvt_pkg::QCNT_W-1:0]       count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (count_reg != sclvt_pkg::QCNT_W'(sclvt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == sclvt_pkg::QPTR_W'(sclvt_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == sclvt_pkg::QPTR_W'(sclvt_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/sclvt_back.sv -----
// ============================================================================
// sclvt_back
// Table sequencer: holds the sorted table in a memory, scans it one entry per
// cycle for the key, shifts later entries back one per cycle and writes the
// new entry; serves reads and drives the registered result.
// ============================================================================
module sclvt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  sclvt_pkg::item_t pop_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       action,
    output logic [4:0]       position,
    output logic [5:0]       fill_level,
    output logic             out_is_extended,
    output logic [10:0]      out_base_id,
    output logic [17:0]      out_ext_id,
    output logic [3:0]       out_length,
    output logic [63:0]      out_payload
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_PUT
    } state_t;

    state_t                          state_reg;
    sclvt_pkg::item_t                item_reg;
    logic [sclvt_pkg::IDX_W-1:0]     idx_reg;
    logic [sclvt_pkg::IDX_W-1:0]     shift_reg;
    logic [sclvt_pkg::CNT_W-1:0]     fill_reg;
    logic [2:0]                      act_reg;

    sclvt_pkg::entry_t               mem [sclvt_pkg::ENTRIES];
    sclvt_pkg::entry_t               rd_data_reg;

    logic                            mem_we;
    logic [sclvt_pkg::IDX_W-1:0]     mem_waddr;
    sclvt_pkg::entry_t               mem_wdata;
    logic                            mem_re;
    logic [sclvt_pkg::IDX_W-1:0]     mem_raddr;

    logic                            out_valid_reg;
    logic [2:0]                      action_reg;
    logic [4:0]                      position_reg;
    logic [5:0]                      fill_level_reg;
    sclvt_pkg::entry_t               out_entry_reg;

    logic                            full;
    logic [sclvt_pkg::IDX_W-1:0]     last_pos;
    logic [sclvt_pkg::CNT_W-1:0]     idx_plus_one;
    logic                            scan_less;
    logic                            scan_equal;
    logic                            read_in_range;
    sclvt_pkg::entry_t               new_entry;
    logic [sclvt_pkg::CNT_W-1:0]     fill_after_put;

    assign full          = (fill_reg == sclvt_pkg::CNT_W'(sclvt_pkg::ENTRIES));
    assign last_pos      = full ? sclvt_pkg::IDX_W'(sclvt_pkg::ENTRIES - 1)
                                : fill_reg[sclvt_pkg::IDX_W-1:0];
    assign idx_plus_one  = sclvt_pkg::CNT_W'(idx_reg) + 1'b1;
    assign scan_less     = (rd_data_reg.key < item_reg.key);
    assign scan_equal    = (rd_data_reg.key == item_reg.key);
    assign read_in_range = (sclvt_pkg::CNT_W'(pop_item.read_index) < fill_reg);
    assign new_entry     = '{key: item_reg.key, length: item_reg.length,
                             payload: item_reg.payload};
    assign fill_after_put = ((act_reg != sclvt_pkg::ACT_REPLACED) && !full)
                            ? fill_reg + 1'b1 : fill_reg;

    // A new request starts only with the result register empty, so the result
    // it leaves behind always has a free place to go.
    assign pop_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = new_entry;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = pop_item.is_read
                                ? sclvt_pkg::IDX_W'(pop_item.read_index) : '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_less)
                begin
                    if (idx_plus_one != fill_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + 1'b1;
                    end
                end
                else if (!scan_equal && (last_pos > idx_reg))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = last_pos - 1'b1;
                end
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = shift_reg;
                mem_wdata = rd_data_reg;
                if ((shift_reg - 1'b1) > idx_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = shift_reg - 2'd2;
                end
            end
            ST_PUT:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            shift_reg      <= '0;
            act_reg        <= sclvt_pkg::ACT_REPLACED;
            item_reg       <= '0;
            action_reg     <= sclvt_pkg::ACT_REPLACED;
            position_reg   <= '0;
            fill_level_reg <= '0;
            out_entry_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid && pop_ready)
                    begin
                        item_reg <= pop_item;
                        idx_reg  <= '0;
                        if (pop_item.is_read)
                        begin
                            if (read_in_range)
                            begin
                                state_reg <= ST_READ;
                            end
                            else
                            begin
                                out_valid_reg  <= 1'b1;
                                action_reg     <= sclvt_pkg::ACT_READ_BAD;
                                position_reg   <= pop_item.read_index;
                                fill_level_reg <= 6'(fill_reg);
                                out_entry_reg  <= '0;
                            end
                        end
                        else if (fill_reg == '0)
                        begin
                            act_reg   <= sclvt_pkg::ACT_APPENDED;
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_READ:
                begin
                    out_valid_reg  <= 1'b1;
                    action_reg     <= sclvt_pkg::ACT_READ_OK;
                    position_reg   <= item_reg.read_index;
                    fill_level_reg <= 6'(fill_reg);
                    out_entry_reg  <= rd_data_reg;
                    state_reg      <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (scan_less)
                    begin
                        if (idx_plus_one != fill_reg)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else if (!full)
                        begin
                            // Larger than every entry: goes at the end.
                            idx_reg   <= fill_reg[sclvt_pkg::IDX_W-1:0];
                            act_reg   <= sclvt_pkg::ACT_APPENDED;
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            action_reg     <= sclvt_pkg::ACT_DROPPED;
                            position_reg   <= '0;
                            fill_level_reg <= 6'(fill_reg);
                            out_entry_reg  <= '0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else if (scan_equal)
                    begin
                        act_reg   <= sclvt_pkg::ACT_REPLACED;
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        act_reg   <= sclvt_pkg::ACT_INSERTED;
                        shift_reg <= last_pos;
                        state_reg <= (last_pos > idx_reg) ? ST_SHIFT : ST_PUT;
                    end
                end
                ST_SHIFT:
                begin
                    shift_reg <= shift_reg - 1'b1;
                    if ((shift_reg - 1'b1) <= idx_reg)
                    begin
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    fill_reg       <= fill_after_put;
                    out_valid_reg  <= 1'b1;
                    action_reg     <= act_reg;
                    position_reg   <= 5'(idx_reg);
                    fill_level_reg <= 6'(fill_after_put);
                    out_entry_reg  <= '0;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign position        = position_reg;
    assign fill_level      = fill_level_reg;
    assign out_is_extended = out_entry_reg.key[29];
    assign out_base_id     = out_entry_reg.key[28:18];
    assign out_ext_id      = out_entry_reg.key[17:0];
    assign out_length      = out_entry_reg.length;
    assign out_payload     = out_entry_reg.payload;

endmodule

// ----- dv/sorted_can_id_last_value_table_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sorted_can_id_last_value_table_top_tb
// Self-checking testbench for the sorted CAN identifier last-value table.
// ============================================================================
// A clocked driver feeds insert and read requests from a pending queue, and a
// shadow copy of the sorted table predicts the response to each accepted
// request. A clocked monitor compares every response with the oldest
// prediction. Stimulus starts with a directed pass over the identifier
// extremes and ordering cases, then random traffic over a small identifier
// pool (many replacements), then random traffic over the full identifier space
// that fills the table and exercises full-table insertion and dropped frames.
module sorted_can_id_last_value_table_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LO    = 320;
    localparam int QUIET_HI    = 420;
    localparam int NARROW_REQS = 200;
    localparam int WIDE_REQS   = 280;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        bit        mode;
        bit        is_ext;
        bit [10:0] base;
        bit [17:0] ext;
        bit [3:0]  len;
        bit [63:0] data;
        bit [4:0]  ridx;
        bit        wait_drain;
    } can_req_t;

    typedef struct {
        bit [2:0]  action;
        bit [4:0]  pos;
        bit [5:0]  fill;
        bit        is_ext;
        bit [10:0] base;
        bit [17:0] ext;
        bit [3:0]  len;
        bit [63:0] data;
    } table_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic        is_extended = 1'b0;
    logic [10:0] base_id = '0;
    logic [17:0] ext_id = '0;
    logic [3:0]  data_length = '0;
    logic [63:0] payload = '0;
    logic [4:0]  read_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  action;
    logic [4:0]  position;
    logic [5:0]  fill_level;
    logic        out_is_extended;
    logic [10:0] out_base_id;
    logic [17:0] out_ext_id;
    logic [3:0]  out_length;
    logic [63:0] out_payload;

    // Shadow copy of the table.
    logic [sclvt_pkg::KEY_W-1:0]  shadow_key [sclvt_pkg::ENTRIES];
    logic [sclvt_pkg::LEN_W-1:0]  shadow_len [sclvt_pkg::ENTRIES];
    logic [sclvt_pkg::DATA_W-1:0] shadow_data [sclvt_pkg::ENTRIES];
    int                           shadow_fill = 0;

    can_req_t    pending_q [$];
    table_resp_t expected_q [$];
    can_req_t    cur_req;
    table_resp_t mon_exp;
    bit [29:0]   key_history [$];

    int  errors = 0;
    int  sent_count = 0;
    int  cycle_count = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    bit  quiet;

    always #1 clk = ~clk;

    sorted_can_id_last_value_table_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .is_extended     (is_extended),
        .base_id         (base_id),
        .ext_id          (ext_id),
        .data_length     (data_length),
        .payload         (payload),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .position        (position),
        .fill_level      (fill_level),
        .out_is_extended (out_is_extended),
        .out_base_id     (out_base_id),
        .out_ext_id      (out_ext_id),
        .out_length      (out_length),
        .out_payload     (out_payload)
    );

    // Applies one request to the shadow table and returns the response it
    // should produce.
    function automatic table_resp_t table_update(input can_req_t r);
        table_resp_t                 e;
        logic [sclvt_pkg::KEY_W-1:0] k;
        int                          i;
        int                          j;
        int                          last;
        e = '{default: 0};
        if (r.mode)
        begin
            e.pos = r.ridx;
            if (int'(r.ridx) < shadow_fill)
            begin
                k        = shadow_key[r.ridx];
                e.action = sclvt_pkg::ACT_READ_OK;
                e.is_ext = k[29];
                e.base   = k[28:18];
                e.ext    = k[17:0];
                e.len    = shadow_len[r.ridx];
                e.data   = shadow_data[r.ridx];
            end
            else
            begin
                e.action = sclvt_pkg::ACT_READ_BAD;
            end
        end
        else
        begin
            // The extension takes no part in the key of a standard frame.
            k = {r.is_ext, r.base, r.is_ext ? r.ext : 18'd0};
            i = 0;
            while (i < shadow_fill && shadow_key[i] < k)
                i++;
            if (i < shadow_fill && shadow_key[i] == k)
            begin
                e.action = sclvt_pkg::ACT_REPLACED;
                e.pos    = 5'(i);
            end
            else if (i < shadow_fill)
            begin
                last = (shadow_fill < sclvt_pkg::ENTRIES) ? shadow_fill
                                                          : sclvt_pkg::ENTRIES - 1;
                for (j = last; j > i; j--)
                begin
                    shadow_key[j]  = shadow_key[j-1];
                    shadow_len[j]  = shadow_len[j-1];
                    shadow_data[j] = shadow_data[j-1];
                end
                if (shadow_fill < sclvt_pkg::ENTRIES)
                    shadow_fill++;
                e.action = sclvt_pkg::ACT_INSERTED;
                e.pos    = 5'(i);
            end
            else if (shadow_fill < sclvt_pkg::ENTRIES)
            begin
                i = shadow_fill;
                shadow_fill++;
                e.action = sclvt_pkg::ACT_APPENDED;
                e.pos    = 5'(i);
            end
            else
            begin
                e.action = sclvt_pkg::ACT_DROPPED;
                e.pos    = '0;
            end
            if (e.action != sclvt_pkg::ACT_DROPPED)
            begin
                shadow_key[i]  = k;
                shadow_len[i]  = r.len;
                shadow_data[i] = r.data;
            end
        end
        e.fill = 6'(shadow_fill);
        return e;
    endfunction

    function automatic can_req_t frame_insert(input bit is_ext, input bit [10:0] base,
                                              input bit [17:0] ext, input bit [3:0] len,
                                              input bit [63:0] data);
        can_req_t r;
        r = '{default: 0};
        r.is_ext = is_ext;
        r.base   = base;
        r.ext    = ext;
        r.len    = len;
        r.data   = data;
        r.ridx   = 5'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic can_req_t frame_read(input bit [4:0] idx);
        can_req_t r;
        r = '{default: 0};
        r.mode   = 1'b1;
        r.is_ext = 1'($urandom_range(0, 1));
        r.base   = 11'($urandom_range(0, 2047));
        r.ext    = 18'($urandom_range(0, 262143));
        r.len    = 4'($urandom_range(0, 8));
        r.data   = {$urandom, $urandom};
        r.ridx   = idx;
        return r;
    endfunction

    // Narrow traffic draws identifiers from a small pool so that most inserts
    // hit an entry already held; wide traffic spans the whole key space.
    task automatic add_random(input int count, input bit narrow);
        bit [10:0] base_pool [8];
        bit [17:0] ext_pool [4];
        can_req_t  r;
        bit [29:0] hk;
        int        n;
        base_pool = '{11'd0, 11'd1, 11'd5, 11'd100, 11'd1023, 11'd1024, 11'd2046, 11'd2047};
        ext_pool  = '{18'd0, 18'd1, 18'h20000, 18'h3FFFF};
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < (narrow ? 30 : 25))
            begin
                r = frame_read(5'($urandom_range(0, 31)));
            end
            else
            begin
                r = frame_insert(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                                 18'($urandom_range(0, 262143)), 4'($urandom_range(0, 8)),
                                 {$urandom, $urandom});
                if (narrow)
                begin
                    r.base = base_pool[$urandom_range(0, 7)];
                    if (r.is_ext || $urandom_range(0, 1))
                        r.ext = ext_pool[$urandom_range(0, 3)];
                end
                else if (key_history.size() != 0 && $urandom_range(0, 99) < 15)
                begin
                    hk       = key_history[$urandom_range(0, key_history.size() - 1)];
                    r.is_ext = hk[29];
                    r.base   = hk[28:18];
                    r.ext    = hk[17:0];
                end
                key_history.push_back({r.is_ext, r.base, r.ext});
            end
            pending_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    assign quiet = (sent_count >= QUIET_LO) && (sent_count < QUIET_HI);

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= 1'b0;
            is_extended <= 1'b0;
            base_id     <= '0;
            ext_id      <= '0;
            data_length <= '0;
            payload     <= '0;
            read_index  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(table_update(cur_req));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() != 0
                    && !(pending_q[0].wait_drain && expected_q.size() != 0)
                    && (quiet || $urandom_range(0, 99) >= 6))
                begin
                    cur_req     = pending_q.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= cur_req.mode;
                    is_extended <= cur_req.is_ext;
                    base_id     <= cur_req.base;
                    ext_id      <= cur_req.ext;
                    data_length <= cur_req.len;
                    payload     <= cur_req.data;
                    read_index  <= cur_req.ridx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor. Once, the receiver holds off long enough for the
    // request queue inside the block to fill and stall the sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: response with no request outstanding: action %0h",
                             $time, action);
                    errors++;
                end
                else
                begin
                    mon_exp = expected_q.pop_front();
                    check_field("action", mon_exp.action, action);
                    check_field("position", mon_exp.pos, position);
                    check_field("fill_level", mon_exp.fill, fill_level);
                    check_field("out_is_extended", mon_exp.is_ext, out_is_extended);
                    check_field("out_base_id", mon_exp.base, out_base_id);
                    check_field("out_ext_id", mon_exp.ext, out_ext_id);
                    check_field("out_length", mon_exp.len, out_length);
                    check_field("out_payload", mon_exp.data, out_payload);
                end
            end
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_can_id_last_value_table_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        can_req_t r;
        int       n;
        // Reads of an empty table, at both ends of the index range.
        pending_q.push_back(frame_read(5'd0));
        pending_q.push_back(frame_read(5'd31));
        // A standard frame keeps no extension, so the later frame with the
        // same base and a different extension replaces it.
        pending_q.push_back(frame_insert(1'b0, 11'd100, 18'h3FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_q.push_back(frame_insert(1'b0, 11'd0, 18'd0, 4'd0, 64'd0));
        pending_q.push_back(frame_insert(1'b0, 11'd2047, 18'd0, 4'd4, 64'h0123_4567_89AB_CDEF));
        pending_q.push_back(frame_insert(1'b1, 11'd0, 18'd0, 4'd1, 64'h0000_0000_0000_00A5));
        pending_q.push_back(frame_insert(1'b1, 11'd2047, 18'h3FFFF, 4'd8,
                                         64'hFEDC_BA98_7654_3210));
        pending_q.push_back(frame_insert(1'b1, 11'd0, 18'h3FFFF, 4'd2, 64'h0000_0000_0000_5A5A));
        pending_q.push_back(frame_insert(1'b0, 11'd100, 18'd0, 4'd3, 64'h0000_0000_00C0_FFEE));
        pending_q.push_back(frame_insert(1'b1, 11'd100, 18'd0, 4'd7, 64'h8000_0000_0000_0001));
        for (n = 0; n < 8; n++)
            pending_q.push_back(frame_read(5'(n)));
        add_random(NARROW_REQS, 1'b1);
        // The sender waits for every response before the wide traffic starts.
        r = frame_insert(1'b1, 11'd1500, 18'h15555, 4'd6, {$urandom, $urandom});
        r.wait_drain = 1'b1;
        pending_q.push_back(r);
        add_random(WIDE_REQS, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sample between clock edges, after the driver and monitor have settled.
        while (pending_q.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected_q.size() == 0)
            $display("sorted_can_id_last_value_table_top regression: pass");
        else
            $display("sorted_can_id_last_value_table_top regression: fail");
        $finish;
    end

endmodule

// ----- sorted_can_id_last_value_table_top.f -----
hdl/sclvt_pkg.sv
hdl/sclvt_front.sv
hdl/sclvt_queue.sv
hdl/sclvt_back.sv
hdl/sorted_can_id_last_value_table_top.sv
dv/sorted_can_id_last_value_table_top_tb.sv
